// ===== rtl/ehd_pkg.sv =====
// Shared constants for the Easter holiday detector: field widths, holiday
// tables, reciprocal constants for the divisions by constants, and the query type.
// No dependencies.
`timescale 1ns / 1ps

package ehd_pkg;

    // Field widths.
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int IDX_W   = 5;
    localparam int EMON_W  = 3;
    localparam int NUM_HOL = 17;

    // Number of register stages, the output register included.
    localparam int NUM_STG = 9;

    localparam logic [NUM_HOL-1:0] ENABLE_RESET = 17'd101373;

    // Reciprocals. Each is exact for the full range of its operand.
    localparam logic [12:0] RECIP_100 = 13'd5243;   // y / 100 = (y * R) >> 19
    localparam logic [11:0] RECIP_19  = 12'd3450;   // y / 19  = (y * R) >> 16
    localparam logic [12:0] RECIP_7Y  = 13'd4682;   // y / 7   = (y * R) >> 15
    localparam logic [10:0] RECIP_3   = 11'd43;     // c / 3   = (c * R) >> 7
    localparam logic [9:0]  RECIP_30  = 10'd547;    // x / 30  = (x * R) >> 14
    localparam logic [8:0]  RECIP_7S  = 9'd293;     // s / 7   = (s * R) >> 11

    // Month codes used by the query decoder.
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;

    // Easter month codes.
    localparam logic [EMON_W-1:0] EASTER_MAR = 3'd3;
    localparam logic [EMON_W-1:0] EASTER_APR = 3'd4;

    // Fixed holidays: index, month, day.
    localparam logic [IDX_W-1:0] FIX_IDX [0:7] = '{
        5'd0, 5'd1, 5'd2, 5'd11, 5'd12, 5'd13, 5'd15, 5'd16
    };
    localparam logic [MONTH_W-1:0] FIX_MONTH [0:7] = '{
        4'd1, 4'd1, 4'd5, 4'd10, 4'd8, 4'd11, 4'd12, 4'd12
    };
    localparam logic [DAY_W-1:0] FIX_DAY [0:7] = '{
        5'd1, 5'd6, 5'd1, 5'd3, 5'd15, 5'd1, 5'd25, 5'd26
    };

    // Movable holidays: index, offset from Good Friday.
    localparam logic [IDX_W-1:0] MOV_IDX [0:6] = '{
        5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10
    };
    localparam logic [6:0] MOV_OFF [0:6] = '{
        7'd0, 7'd2, 7'd3, 7'd41, 7'd51, 7'd52, 7'd62
    };

    // Query features that travel beside the Easter computation.
    typedef struct packed {
        logic [NUM_HOL-1:0] fix_hit;   // fixed holidays matched by month and day
        logic [6:0]         mday;      // day counted from the end of February
        logic               mday_ok;   // query is a real date from March to June
    } t_qry;

endpackage

// ===== rtl/easter_holiday_detector.sv =====
// Top level of the Easter holiday detector: a nine-stage pipeline that computes
// Easter Sunday per year and matches the queried date against the holidays.
// Depends on ehd_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// query     in         i_valid / o_ready     i_year, i_month, i_day
// result    out        o_valid / i_ready     o_is_holiday, o_holiday_index,
//                                            o_easter_month, o_easter_day
// config    in         i_cfg_we              i_cfg_wdata (holiday enable mask)
//
// One request enters per cycle unless a stalled output has backed the pipeline up.
// Each request passes through nine register stages, the output register included.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled output fills bubbles and loses nothing.
// Synchronous active-low reset clears the valid bits and restores the mask.

module easter_holiday_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ehd_pkg::YEAR_W-1:0]    i_year,
    input  logic [ehd_pkg::MONTH_W-1:0]   i_month,
    input  logic [ehd_pkg::DAY_W-1:0]     i_day,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_holiday,
    output logic [ehd_pkg::IDX_W-1:0]     o_holiday_index,
    output logic [ehd_pkg::EMON_W-1:0]    o_easter_month,
    output logic [ehd_pkg::DAY_W-1:0]     o_easter_day,
    input  logic                          i_cfg_we,
    input  logic [ehd_pkg::NUM_HOL-1:0]   i_cfg_wdata
);

    // Stage control.
    logic [ehd_pkg::NUM_STG-1:0] r_v;
    logic [ehd_pkg::NUM_STG-1:0] ld;
    logic [ehd_pkg::NUM_HOL-1:0] r_holiday_enable;

    // Query features, one register set per stage up to the matcher.
    ehd_pkg::t_qry n_qry;
    ehd_pkg::t_qry r_qry [0:ehd_pkg::NUM_STG-2];

    // Stage 1.
    logic [ehd_pkg::YEAR_W-1:0] r_s1_year;
    logic [24:0] r_s1_p100;
    logic [23:0] r_s1_p19;
    logic [24:0] r_s1_p7;
    // Stage 2.
    logic [5:0]  n_s2_n;
    logic [4:0]  n_s2_r19;
    logic [2:0]  n_s2_r7;
    logic [10:0] n_s2_p300;
    logic [5:0]  r_s2_n;
    logic [4:0]  r_s2_r19;
    logic [2:0]  r_s2_r7;
    logic [1:0]  r_s2_ylo;
    logic [10:0] r_s2_p300;
    // Stage 3.
    logic [5:0]  n_s3_m;
    logic [8:0]  n_s3_araw;
    logic [5:0]  r_s3_m;
    logic [8:0]  r_s3_araw;
    logic [5:0]  r_s3_n;
    logic [2:0]  r_s3_r7;
    logic [1:0]  r_s3_ylo;
    // Stage 4.
    logic [17:0] r_s4_p30a;
    logic [8:0]  r_s4_t11;
    logic [8:0]  r_s4_araw;
    logic [5:0]  r_s4_n;
    logic [2:0]  r_s4_r7;
    logic [1:0]  r_s4_ylo;
    // Stage 5.
    logic [4:0]  n_s5_a;
    logic [4:0]  r_s5_a;
    logic [18:0] r_s5_p30m;
    logic [8:0]  r_s5_t11;
    logic [5:0]  r_s5_n;
    logic [2:0]  r_s5_r7;
    logic [1:0]  r_s5_ylo;
    // Stage 6.
    logic        n_s6_cond;
    logic [7:0]  n_s6_esum;
    logic        r_s6_cond;
    logic [7:0]  r_s6_esum;
    logic [4:0]  r_s6_a;
    // Stage 7.
    logic [16:0] r_s7_pe;
    logic [7:0]  r_s7_esum;
    logic [4:0]  r_s7_a;
    logic        r_s7_cond;
    // Stage 8.
    logic [ehd_pkg::EMON_W-1:0] n_s8_em;
    logic [ehd_pkg::DAY_W-1:0]  n_s8_ed;
    logic [6:0]                 n_s8_base;
    logic [ehd_pkg::EMON_W-1:0] r_s8_em;
    logic [ehd_pkg::DAY_W-1:0]  r_s8_ed;
    logic [6:0]                 r_s8_base;
    // Output stage.
    logic                        n_o_is;
    logic [ehd_pkg::IDX_W-1:0]   n_o_idx;
    logic                        r_o_is;
    logic [ehd_pkg::IDX_W-1:0]   r_o_idx;
    logic [ehd_pkg::EMON_W-1:0]  r_o_em;
    logic [ehd_pkg::DAY_W-1:0]   r_o_ed;

    // A stage loads when it is empty or its successor loads.
    always_comb begin
        ld[ehd_pkg::NUM_STG-1] = !r_v[ehd_pkg::NUM_STG-1] || i_ready;
        for (int k = ehd_pkg::NUM_STG - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[ehd_pkg::NUM_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < ehd_pkg::NUM_STG; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Holiday enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holiday_enable <= ehd_pkg::ENABLE_RESET;
        end else if (i_cfg_we) begin
            r_holiday_enable <= i_cfg_wdata;
        end
    end

    // Query decode: fixed holiday hits and the day counted from March 1.
    always_comb begin
        logic [6:0]                 mon_off;
        logic [ehd_pkg::DAY_W-1:0]  mon_len;
        logic                       in_range;
        mon_off  = 7'd0;
        mon_len  = 5'd0;
        in_range = 1'b1;
        n_qry    = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_month == ehd_pkg::FIX_MONTH[k] && i_day == ehd_pkg::FIX_DAY[k]) begin
                n_qry.fix_hit[ehd_pkg::FIX_IDX[k]] = 1'b1;
            end
        end
        case (i_month)
            ehd_pkg::MON_MAR: begin
                mon_off = 7'd0;
                mon_len = 5'd31;
            end
            ehd_pkg::MON_APR: begin
                mon_off = 7'd31;
                mon_len = 5'd30;
            end
            ehd_pkg::MON_MAY: begin
                mon_off = 7'd61;
                mon_len = 5'd31;
            end
            ehd_pkg::MON_JUN: begin
                mon_off = 7'd92;
                mon_len = 5'd30;
            end
            default: begin
                in_range = 1'b0;
            end
        endcase
        n_qry.mday    = 7'(mon_off + 7'(i_day));
        n_qry.mday_ok = in_range && (i_day != 5'd0) && (i_day <= mon_len);
    end

    // Query features travel down the pipeline beside the Easter math.
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_qry[0] <= n_qry;
        end
        for (int k = 1; k < ehd_pkg::NUM_STG - 1; k++) begin
            if (ld[k]) begin
                r_qry[k] <= r_qry[k-1];
            end
        end
    end

    // Stage 1: reciprocal products of the year.
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s1_year <= i_year;
            r_s1_p100 <= 25'(i_year) * 25'(ehd_pkg::RECIP_100);
            r_s1_p19  <= 24'(i_year) * 24'(ehd_pkg::RECIP_19);
            r_s1_p7   <= 25'(i_year) * 25'(ehd_pkg::RECIP_7Y);
        end
    end

    // Stage 2: centuries, year mod 19, year mod 7, the century sum n, and the product for q100 / 3.
    always_comb begin
        logic [5:0]  q100;
        logic [7:0]  q19;
        logic [9:0]  q7;
        q100      = r_s1_p100[24:19];
        q19       = r_s1_p19[23:16];
        q7        = r_s1_p7[24:15];
        n_s2_r19  = 5'(r_s1_year - 12'(q19) * 12'd19);
        n_s2_r7   = 3'(r_s1_year - 12'(q7) * 12'd7);
        n_s2_n    = 6'(q100 - {2'b00, q100[5:2]} + 6'd4);
        n_s2_p300 = 11'(q100) * ehd_pkg::RECIP_3;
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s2_n    <= n_s2_n;
            r_s2_r19  <= n_s2_r19;
            r_s2_r7   <= n_s2_r7;
            r_s2_ylo  <= r_s1_year[1:0];
            r_s2_p300 <= n_s2_p300;
        end
    end

    // Stage 3: lunar correction m and the raw epact sum.
    always_comb begin
        logic [3:0] q300;
        q300      = r_s2_p300[10:7];
        n_s3_m    = 6'(r_s2_n - 6'(q300) + 6'd11);
        n_s3_araw = 9'(9'(r_s2_r19) * 9'd19 + 9'(n_s3_m));
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s3_m    <= n_s3_m;
            r_s3_araw <= n_s3_araw;
            r_s3_n    <= r_s2_n;
            r_s3_r7   <= r_s2_r7;
            r_s3_ylo  <= r_s2_ylo;
        end
    end

    // Stage 4: reciprocal product for the epact, and 11 * (m + 1).
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s4_p30a <= 18'(r_s3_araw) * 18'(ehd_pkg::RECIP_30);
            r_s4_t11  <= 9'((9'(r_s3_m) + 9'd1) * 9'd11);
            r_s4_araw <= r_s3_araw;
            r_s4_n    <= r_s3_n;
            r_s4_r7   <= r_s3_r7;
            r_s4_ylo  <= r_s3_ylo;
        end
    end

    // Stage 5: epact a, and the reciprocal product for the April 25 test.
    always_comb begin
        logic [3:0] q30;
        q30    = r_s4_p30a[17:14];
        n_s5_a = 5'(r_s4_araw - 9'(q30) * 9'd30);
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s5_a    <= n_s5_a;
            r_s5_p30m <= 19'(r_s4_t11) * 19'(ehd_pkg::RECIP_30);
            r_s5_t11  <= r_s4_t11;
            r_s5_n    <= r_s4_n;
            r_s5_r7   <= r_s4_r7;
            r_s5_ylo  <= r_s4_ylo;
        end
    end

    // Stage 6: April 25 condition and the weekday sum.
    always_comb begin
        logic [4:0] qm;
        logic [8:0] rem;
        qm        = r_s5_p30m[18:14];
        rem       = 9'(r_s5_t11 - 9'(qm) * 9'd30);
        n_s6_cond = rem < 9'd19;
        n_s6_esum = 8'(8'({r_s5_ylo, 1'b0}) + 8'({r_s5_r7, 2'b00})
                       + 8'(r_s5_a) * 8'd6 + 8'(r_s5_n));
    end

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_s6_cond <= n_s6_cond;
            r_s6_esum <= n_s6_esum;
            r_s6_a    <= r_s5_a;
        end
    end

    // Stage 7: reciprocal product for the weekday remainder.
    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_s7_pe   <= 17'(r_s6_esum) * 17'(ehd_pkg::RECIP_7S);
            r_s7_esum <= r_s6_esum;
            r_s7_a    <= r_s6_a;
            r_s7_cond <= r_s6_cond;
        end
    end

    // Stage 8: Easter date with its two April exceptions, and Good Friday
    // counted from March 1.
    always_comb begin
        logic [5:0] qe;
        logic [2:0] e;
        logic [5:0] s;
        logic [4:0] bb;
        logic [5:0] mday;
        qe = r_s7_pe[16:11];
        e  = 3'(r_s7_esum - 8'(qe) * 8'd7);
        s  = 6'(e) + 6'(r_s7_a);
        bb = 5'(s - 6'd9);
        if (s < 6'd10) begin
            n_s8_em = ehd_pkg::EASTER_MAR;
            n_s8_ed = 5'(s + 6'd22);
            mday    = 6'(n_s8_ed);
        end else begin
            if (bb == 5'd26 || (r_s7_a == 5'd28 && bb == 5'd25 && r_s7_cond)) begin
                bb = 5'(bb - 5'd7);
            end
            n_s8_em = ehd_pkg::EASTER_APR;
            n_s8_ed = bb;
            mday    = 6'(6'(bb) + 6'd31);
        end
        n_s8_base = 7'(7'(mday) - 7'd2);
    end

    always_ff @(posedge i_clk) begin
        if (ld[7]) begin
            r_s8_em   <= n_s8_em;
            r_s8_ed   <= n_s8_ed;
            r_s8_base <= n_s8_base;
        end
    end

    // Stage 9: movable matches, enable mask, lowest enabled index.
    always_comb begin
        logic [ehd_pkg::NUM_HOL-1:0] hits;
        logic [ehd_pkg::NUM_HOL-1:0] en_hits;
        logic [ehd_pkg::NUM_HOL-1:0] lowest;
        ehd_pkg::t_qry               q;
        q    = r_qry[ehd_pkg::NUM_STG-2];
        hits = q.fix_hit;
        for (int k = 0; k < 7; k++) begin
            if (q.mday_ok && q.mday == 7'(r_s8_base + ehd_pkg::MOV_OFF[k])) begin
                hits[ehd_pkg::MOV_IDX[k]] = 1'b1;
            end
        end
        en_hits = hits & r_holiday_enable;
        lowest  = en_hits & (~en_hits + 17'd1);
        n_o_is  = |en_hits;
        n_o_idx = '0;
        for (int i = 0; i < ehd_pkg::NUM_HOL; i++) begin
            n_o_idx = n_o_idx | (lowest[i] ? ehd_pkg::IDX_W'(i) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[8]) begin
            r_o_is  <= n_o_is;
            r_o_idx <= n_o_idx;
            r_o_em  <= r_s8_em;
            r_o_ed  <= r_s8_ed;
        end
    end

    assign o_is_holiday    = r_o_is;
    assign o_holiday_index = r_o_idx;
    assign o_easter_month  = r_o_em;
    assign o_easter_day    = r_o_ed;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Easter holiday detector: drives date requests,
// predicts every result from its own calendar arithmetic and checks each one.
// Depends on ehd_pkg and easter_holiday_detector.
`timescale 1ns / 1ps

module tb_top;

    // Holiday indexes as the enable mask numbers them.
    localparam logic [4:0] HOL_NEW_YEAR    = 5'd0;
    localparam logic [4:0] HOL_EPIPHANY    = 5'd1;
    localparam logic [4:0] HOL_LABOR_DAY   = 5'd2;
    localparam logic [4:0] HOL_GOOD_FRIDAY = 5'd4;
    localparam logic [4:0] HOL_EASTER_SUN  = 5'd5;
    localparam logic [4:0] HOL_EASTER_MON  = 5'd6;
    localparam logic [4:0] HOL_ASCENSION   = 5'd7;
    localparam logic [4:0] HOL_WHIT_SUN    = 5'd8;
    localparam logic [4:0] HOL_WHIT_MON    = 5'd9;
    localparam logic [4:0] HOL_CORPUS      = 5'd10;
    localparam logic [4:0] HOL_UNITY_DAY   = 5'd11;
    localparam logic [4:0] HOL_ASSUMPTION  = 5'd12;
    localparam logic [4:0] HOL_ALL_SAINTS  = 5'd13;
    localparam logic [4:0] HOL_CHRISTMAS   = 5'd15;
    localparam logic [4:0] HOL_BOXING_DAY  = 5'd16;

    localparam logic [16:0] MASK_NONE = 17'h00000;
    localparam logic [16:0] MASK_ALL  = 17'h1FFFF;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [4:0] idx;
        logic [3:0] mo;
        logic [4:0] dy;
    } fixed_entry_t;

    typedef struct packed {
        logic [4:0] idx;
        logic [6:0] off;
    } movable_entry_t;

    typedef struct packed {
        logic [3:0] mo;
        logic [4:0] dy;
    } date_t;

    typedef struct packed {
        logic [2:0] em;
        logic [4:0] ed;
    } easter_t;

    typedef struct packed {
        logic       hol;
        logic [4:0] idx;
        logic [2:0] em;
        logic [4:0] ed;
    } holiday_answer_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [11:0] i_year      = '0;
    logic [3:0]  i_month     = '0;
    logic [4:0]  i_day       = '0;
    logic        i_ready     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        o_ready;
    logic        o_valid;
    logic        o_is_holiday;
    logic [4:0]  o_holiday_index;
    logic [2:0]  o_easter_month;
    logic [4:0]  o_easter_day;

    // Predictor copy of the enable register and the answers still owed.
    logic [16:0]     enable_mask = ehd_pkg::ENABLE_RESET;
    holiday_answer_t pending_answers[$];
    int              mismatches    = 0;
    bit              idling_on     = 1'b1;
    int              hold_requests = 0;
    int              holds_seen    = 0;
    int              ready_hold    = 0;
    int              ready_gap     = 0;
    int              quiet_cycles  = 0;

    easter_holiday_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_is_holiday    (o_is_holiday),
        .o_holiday_index (o_holiday_index),
        .o_easter_month  (o_easter_month),
        .o_easter_day    (o_easter_day),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Fixed-date holidays, one per table slot.
    function automatic fixed_entry_t fixed_holiday(input int k);
        fixed_entry_t f;
        case (k)
            0:       f = '{HOL_NEW_YEAR,    4'd1,  5'd1};
            1:       f = '{HOL_EPIPHANY,    4'd1,  5'd6};
            2:       f = '{HOL_LABOR_DAY,   4'd5,  5'd1};
            3:       f = '{HOL_UNITY_DAY,   4'd10, 5'd3};
            4:       f = '{HOL_ASSUMPTION,  4'd8,  5'd15};
            5:       f = '{HOL_ALL_SAINTS,  4'd11, 5'd1};
            6:       f = '{HOL_CHRISTMAS,   4'd12, 5'd25};
            default: f = '{HOL_BOXING_DAY,  4'd12, 5'd26};
        endcase
        return f;
    endfunction

    // Movable holidays, offsets counted from Good Friday.
    function automatic movable_entry_t movable_holiday(input int k);
        movable_entry_t mv;
        case (k)
            0:       mv = '{HOL_GOOD_FRIDAY, 7'd0};
            1:       mv = '{HOL_EASTER_SUN,  7'd2};
            2:       mv = '{HOL_EASTER_MON,  7'd3};
            3:       mv = '{HOL_ASCENSION,   7'd41};
            4:       mv = '{HOL_WHIT_SUN,    7'd51};
            5:       mv = '{HOL_WHIT_MON,    7'd52};
            default: mv = '{HOL_CORPUS,      7'd62};
        endcase
        return mv;
    endfunction

    function automatic int unsigned month_days(input int unsigned mo, input logic leap);
        case (mo)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Gauss's rule with the year/300 lunar term and the two late-April exceptions.
    function automatic easter_t easter_date(input logic [11:0] y);
        int unsigned yy, n, m, a, e;
        int          b;
        easter_t     r;
        yy = y;
        n  = yy / 100 - yy / 400 + 4;
        m  = n - yy / 300 + 11;
        a  = ((yy % 19) * 19 + m) % 30;
        e  = ((yy % 4) * 2 + 4 * yy + 6 * a + n) % 7;
        b  = int'(e + a) - 9;
        if (b < 1) begin
            r.em = ehd_pkg::EASTER_MAR;
            r.ed = 5'(31 + b);
        end else begin
            if (b == 26 || (a == 28 && b == 25 && ((11 * (m + 1)) % 30) < 19)) begin
                b = b - 7;
            end
            r.em = ehd_pkg::EASTER_APR;
            r.ed = 5'(b);
        end
        return r;
    endfunction

    // Calendar date that lies a given number of days after Good Friday.
    function automatic date_t offset_date(input logic [11:0] y, input int unsigned off);
        easter_t     e;
        logic        leap;
        int unsigned d, mo;
        date_t       r;
        e    = easter_date(y);
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        d    = 31 + month_days(2, leap) + ((e.em == ehd_pkg::EASTER_APR) ? 31 : 0)
               + e.ed - 2 + off;
        mo   = 1;
        while (mo < 12 && d > month_days(mo, leap)) begin
            d  = d - month_days(mo, leap);
            mo = mo + 1;
        end
        r.mo = 4'(mo);
        r.dy = 5'(d);
        return r;
    endfunction

    // Expected result for one date under the given enable mask.
    function automatic holiday_answer_t holiday_lookup(input logic [11:0] y,
                                                       input logic [3:0] mo,
                                                       input logic [4:0] dy,
                                                       input logic [16:0] mask);
        easter_t         e;
        fixed_entry_t    f;
        movable_entry_t  mv;
        date_t           d;
        logic [16:0]     match;
        logic [16:0]     hits;
        holiday_answer_t ans;
        e     = easter_date(y);
        match = '0;
        for (int k = 0; k < 8; k++) begin
            f = fixed_holiday(k);
            if (mo == f.mo && dy == f.dy) match[f.idx] = 1'b1;
        end
        for (int k = 0; k < 7; k++) begin
            mv = movable_holiday(k);
            d  = offset_date(y, mv.off);
            if (mo == d.mo && dy == d.dy) match[mv.idx] = 1'b1;
        end
        hits    = match & mask;
        ans.hol = |hits;
        ans.idx = '0;
        for (int i = 16; i >= 0; i--) begin
            if (hits[i]) ans.idx = 5'(i);
        end
        ans.em = e.em;
        ans.ed = e.ed;
        return ans;
    endfunction

    // Offer one request and hold it until accepted; called at a falling edge.
    task automatic send_query(input logic [11:0] y, input logic [3:0] mo,
                              input logic [4:0] dy);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap     = $urandom_range(1, 16);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_year  = y;
        i_month = mo;
        i_day   = dy;
        do @(posedge i_clk); while (!o_ready);
        pending_answers.push_back(holiday_lookup(y, mo, dy, enable_mask));
        @(negedge i_clk);
    endtask

    // Mostly real holiday dates of random years, the rest near misses and noise.
    task automatic send_random_query();
        logic [11:0]    y;
        date_t          d;
        fixed_entry_t   f;
        movable_entry_t mv;
        int             sel;
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0) y = 12'($urandom_range(0, 4095));
        else y = 12'($urandom_range(1583, 4095));
        if (sel <= 2) begin
            f    = fixed_holiday($urandom_range(0, 7));
            d.mo = f.mo;
            d.dy = f.dy;
        end else if (sel <= 6) begin
            mv = movable_holiday($urandom_range(0, 6));
            d  = offset_date(y, mv.off);
        end else if (sel == 7) begin
            mv = movable_holiday($urandom_range(0, 6));
            d  = offset_date(y, mv.off);
            if ($urandom_range(0, 1) == 0) d.dy = 5'(d.dy + 5'd1);
            else d.dy = 5'(d.dy - 5'd1);
        end else begin
            d.mo = 4'($urandom_range(0, 15));
            d.dy = 5'($urandom_range(0, 31));
        end
        send_query(y, d.mo, d.dy);
    endtask

    // Stop offering, wait for every owed result, then let the pipeline settle.
    task automatic drain_results();
        i_valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (ehd_pkg::NUM_STG + 2) @(negedge i_clk);
    endtask

    // Write the enable register; only called with the block idle.
    task automatic write_enable_mask(input logic [16:0] mask);
        drain_results();
        i_cfg_wdata = mask;
        i_cfg_we    = 1'b1;
        enable_mask = mask;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Every fixed and movable date, both Easter exceptions, a March Easter and odd dates.
    task automatic test_fixed_and_movable_dates();
        fixed_entry_t   f;
        movable_entry_t mv;
        date_t          d;
        for (int k = 0; k < 8; k++) begin
            f = fixed_holiday(k);
            send_query(12'd2024, f.mo, f.dy);
        end
        for (int k = 0; k < 7; k++) begin
            mv = movable_holiday(k);
            d  = offset_date(12'd1981, mv.off);
            send_query(12'd1981, d.mo, d.dy);
        end
        d = offset_date(12'd1954, 2);
        send_query(12'd1954, d.mo, d.dy);
        d = offset_date(12'd2008, 2);
        send_query(12'd2008, d.mo, d.dy);
        send_query(12'd0, 4'd0, 5'd0);
        send_query(12'd4095, 4'd15, 5'd31);
        send_query(12'd1583, 4'd2, 5'd30);
        send_query(12'd2100, 4'd2, 5'd29);
        send_query(12'd2000, 4'd4, 5'd31);
    endtask

    // Random requests under empty, full, random, one-hot and inverted reset enable masks.
    task automatic test_enable_mask_sweep();
        logic [16:0] masks[6];
        masks[0] = MASK_NONE;
        masks[1] = MASK_ALL;
        masks[2] = 17'($urandom_range(0, 17'h1FFFF));
        masks[3] = 17'd1 << $urandom_range(0, 16);
        masks[4] = 17'($urandom_range(0, 17'h1FFFF));
        masks[5] = ~ehd_pkg::ENABLE_RESET;
        for (int p = 0; p < 6; p++) begin
            write_enable_mask(masks[p]);
            repeat (70) send_random_query();
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        write_enable_mask(MASK_ALL);
        hold_requests = hold_requests + 1;
        repeat (60) send_random_query();
    endtask

    // Back-to-back requests with both sides always ready.
    task automatic test_full_rate_stream();
        write_enable_mask(17'($urandom_range(0, 17'h1FFFF)));
        idling_on = 1'b0;
        repeat (150) send_random_query();
    endtask

    // Receiver: random stall bursts, plus a long hold when a test asks for one.
    always @(negedge i_clk) begin
        if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            ready_hold = HOLD_CYCLES;
        end
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready    = 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap = ready_gap - 1;
            i_ready   = 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            ready_gap = int'($urandom_range(1, 16)) - 1;
            i_ready   = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Compare each accepted result with the oldest owed answer.
    always @(posedge i_clk) begin
        holiday_answer_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with no request pending: expected none, actual %0d/%0d",
                         $time, o_is_holiday, o_holiday_index);
                mismatches = mismatches + 1;
            end else begin
                want = pending_answers.pop_front();
                check_field("is_holiday", want.hol, o_is_holiday);
                check_field("holiday_index", want.idx, o_holiday_index);
                check_field("easter_month", want.em, o_easter_month);
                check_field("easter_day", want.ed, o_easter_day);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_fixed_and_movable_dates();
        test_enable_mask_sweep();
        test_output_backpressure();
        test_full_rate_stream();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
